// ===== rtl/core/trlb_pkg.sv =====
// ----------------------------------------------------------------------------
// trlb_pkg
// Shared widths, register indexes and the queue entry type of the tracer
// ratio and level bounds block.
// ----------------------------------------------------------------------------
package trlb_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int DIVR_W = 52;
  localparam int NUM_W  = DATA_W + FRAC_W;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_RHS_MULT  = 2'd1;

  localparam logic [31:0] TIME_STEP_RST = 32'd65536;
  localparam logic [1:0]  RHS_MULT_RST  = 2'd0;
  localparam logic [1:0]  MULT_MERGE    = 2'd1;

  localparam logic signed [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DIVR_W-1:0] divisor;
    logic signed [DATA_W-1:0] mass;
    logic signed [DATA_W-1:0] pmin;
    logic signed [DATA_W-1:0] pmax;
    logic                     last;
  } entry_t;

endpackage

// ===== rtl/core/trlb_front.sv =====
// ----------------------------------------------------------------------------
// trlb_front
// Accepts grid points, forms the updated thickness and queues the work.
// ----------------------------------------------------------------------------
module trlb_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [31:0]             in_thickness,
  input  logic [31:0]             in_divergence,
  input  logic [31:0]             in_tracer_mass,
  input  logic [31:0]             in_prior_min,
  input  logic [31:0]             in_prior_max,
  input  logic                    in_last_in_level,
  input  logic [31:0]             time_step,
  input  logic [1:0]              rhs_mult,
  output logic                    push,
  output trlb_pkg::entry_t        push_entry,
  input  logic                    full
);
  import trlb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_PUSH} state_t;

  state_t                   state_r;
  logic signed [DATA_W-1:0] thick_r, mass_r, pmin_r, pmax_r;
  logic                     last_r, dneg_r;
  logic [31:0]              dmag_r;
  logic [63:0]              pmag_r;
  logic signed [63:0]       prod;
  logic [47:0]              scaled;
  logic [50:0]              term;

  always_comb begin
    prod       = dneg_r ? -$signed(pmag_r) : $signed(pmag_r);
    scaled     = 48'(prod >>> FRAC_W);
    term       = {{3{scaled[47]}}, scaled} * 51'(rhs_mult);
    push_entry.divisor = {{(DIVR_W-DATA_W){thick_r[DATA_W-1]}}, thick_r}
                         - {{(DIVR_W-51){term[50]}}, term};
    push_entry.mass = mass_r;
    push_entry.pmin = pmin_r;
    push_entry.pmax = pmax_r;
    push_entry.last = last_r;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign push     = (state_r == ST_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            thick_r <= in_thickness;
            mass_r  <= in_tracer_mass;
            pmin_r  <= in_prior_min;
            pmax_r  <= in_prior_max;
            last_r  <= in_last_in_level;
            dneg_r  <= in_divergence[31];
            dmag_r  <= in_divergence[31] ? 32'd0 - in_divergence : in_divergence;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          pmag_r  <= 64'(time_step) * 64'(dmag_r);
          state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/trlb_queue.sv =====
// ----------------------------------------------------------------------------
// trlb_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module trlb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  trlb_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output trlb_pkg::entry_t head,
  output logic             empty
);
  import trlb_pkg::*;

  entry_t     slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/core/trlb_back.sv =====
// ----------------------------------------------------------------------------
// trlb_back
// Divides one bit per cycle, saturates the ratio, tracks the level bounds
// and holds the result register.
// ----------------------------------------------------------------------------
module trlb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  trlb_pkg::entry_t head,
  output logic             pop,
  input  logic [1:0]       rhs_mult,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_ratio,
  output logic [30:0]      out_level_min,
  output logic [31:0]      out_level_max,
  output logic             out_level_done,
  output logic             out_divide_fault
);
  import trlb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

  state_t                   state_r;
  logic [5:0]               cnt_r;
  logic [DIVR_W-1:0]        dmag_r, rem_r;
  logic [NUM_W-1:0]         quo_r;
  logic                     zero_r, neg_r, last_r, out_valid_r;
  logic signed [DATA_W-1:0] mass_r, pmin_r, pmax_r, run_min_r, run_max_r;
  logic [DIVR_W:0]          trial;
  logic                     qbit;
  logic [DATA_W-1:0]        nmag;
  logic signed [DATA_W-1:0] ratio, new_min, new_max, lo, hi;
  logic                     fault, can_out;

  always_comb begin
    nmag  = head.mass[DATA_W-1] ? DATA_W'(0) - head.mass : head.mass;
    trial = {rem_r, quo_r[NUM_W-1]};
    qbit  = (trial >= {1'b0, dmag_r});
    if (zero_r) begin
      fault = 1'b1;
      ratio = (mass_r == '0) ? '0 : (mass_r[DATA_W-1] ? NEG_LIM : POS_LIM);
    end else if (neg_r) begin
      fault = (quo_r > NUM_W'(unsigned'(NEG_LIM)));
      ratio = fault ? NEG_LIM : DATA_W'(0) - quo_r[DATA_W-1:0];
    end else begin
      fault = (quo_r > NUM_W'(unsigned'(POS_LIM)));
      ratio = fault ? POS_LIM : quo_r[DATA_W-1:0];
    end
    new_min = (ratio < run_min_r) ? ratio : run_min_r;
    new_max = (ratio > run_max_r) ? ratio : run_max_r;
    lo = new_min;
    hi = new_max;
    if (rhs_mult == MULT_MERGE) begin
      if (pmin_r < lo) lo = pmin_r;
      if (pmax_r > hi) hi = pmax_r;
    end
    if (lo < 0) lo = '0;
    can_out = !out_valid_r || !out_stall;
  end

  assign pop       = (state_r == ST_IDLE) && !empty;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      run_min_r   <= POS_LIM;
      run_max_r   <= NEG_LIM;
    end else begin
      if (state_r == ST_FIN && can_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!empty) begin
            mass_r <= head.mass;
            pmin_r <= head.pmin;
            pmax_r <= head.pmax;
            last_r <= head.last;
            zero_r <= (head.divisor == '0);
            neg_r  <= head.mass[DATA_W-1] ^ head.divisor[DIVR_W-1];
            dmag_r <= head.divisor[DIVR_W-1] ? DIVR_W'(0) - head.divisor : head.divisor;
            rem_r  <= '0;
            quo_r  <= {nmag, {FRAC_W{1'b0}}};
            cnt_r  <= '0;
            state_r <= (head.divisor == '0) ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= qbit ? DIVR_W'(trial - {1'b0, dmag_r}) : trial[DIVR_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], qbit};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(NUM_W - 1)) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (can_out) begin
            out_ratio        <= ratio;
            out_divide_fault <= fault;
            out_level_done   <= last_r;
            if (last_r) begin
              out_level_min <= lo[30:0];
              out_level_max <= hi;
              run_min_r     <= POS_LIM;
              run_max_r     <= NEG_LIM;
            end else begin
              out_level_min <= '0;
              out_level_max <= '0;
              run_min_r     <= new_min;
              run_max_r     <= new_max;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/tracer_ratio_level_bounds.sv =====
// ----------------------------------------------------------------------------
// tracer_ratio_level_bounds
// Tracer ratio per grid point with running per-level minimum and maximum.
// Points pass the front (capture, multiply, push), a two-entry queue and
// the back (bit-serial divide, finish); a zero divisor skips the divide.
// Front and back each take a new point only when done with the last one.
// Synchronous reset sets dt to 1.0, the multiplier to 0 and clears bounds.
// ----------------------------------------------------------------------------
module tracer_ratio_level_bounds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_thickness,
  input  logic [31:0] in_divergence,
  input  logic [31:0] in_tracer_mass,
  input  logic [31:0] in_prior_min,
  input  logic [31:0] in_prior_max,
  input  logic        in_last_in_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_ratio,
  output logic [30:0] out_level_min,
  output logic [31:0] out_level_max,
  output logic        out_level_done,
  output logic        out_divide_fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import trlb_pkg::*;

  logic [31:0] time_step_r;
  logic [1:0]  rhs_mult_r;
  logic        push, full, pop, empty;
  entry_t      push_entry, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      rhs_mult_r  <= RHS_MULT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIME_STEP: time_step_r <= cfg_data;
        REG_RHS_MULT:  rhs_mult_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  trlb_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_thickness, .in_divergence,
    .in_tracer_mass, .in_prior_min, .in_prior_max, .in_last_in_level,
    .time_step(time_step_r), .rhs_mult(rhs_mult_r),
    .push, .push_entry, .full
  );

  trlb_queue u_queue (
    .clk, .rst_n, .push, .push_entry, .full, .pop, .head, .empty
  );

  trlb_back u_back (
    .clk, .rst_n, .empty, .head, .pop, .rhs_mult(rhs_mult_r),
    .out_valid, .out_stall, .out_ratio, .out_level_min, .out_level_max,
    .out_level_done, .out_divide_fault
  );
endmodule

// ===== tb/sv/tb_tracer_ratio_level_bounds.sv =====
// ----------------------------------------------------------------------------
// tb_tracer_ratio_level_bounds
// Self-checking testbench for the tracer ratio and level bounds block. A
// driver streams grid points from a queue and a monitor compares every
// result with a built-in predictor of the ratio and level bounds, across
// several time step and multiplier settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tracer_ratio_level_bounds;
  import trlb_pkg::*;

  typedef struct {
    logic signed [31:0] thick;
    logic signed [31:0] div;
    logic signed [31:0] mass;
    logic signed [31:0] pmin;
    logic signed [31:0] pmax;
    logic               last_pt;
  } point_t;

  typedef struct {
    logic [31:0] ratio;
    logic [30:0] lmin;
    logic [31:0] lmax;
    logic        done;
    logic        fault;
  } bounds_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_thickness = '0;
  logic [31:0] in_divergence = '0;
  logic [31:0] in_tracer_mass = '0;
  logic [31:0] in_prior_min = '0;
  logic [31:0] in_prior_max = '0;
  logic        in_last_in_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_ratio;
  logic [30:0] out_level_min;
  logic [31:0] out_level_max;
  logic        out_level_done;
  logic        out_divide_fault;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  tracer_ratio_level_bounds uut (.*);

  always #5 clk = ~clk;

  point_t  pending_points[$];
  bounds_t expected_bounds[$];
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  int      errors = 0;
  int      results_seen = 0;
  int      levels_seen = 0;
  int      faults_seen = 0;
  int      quiet_cycles = 0;

  logic [31:0] dt_q16 = TIME_STEP_RST;
  logic [1:0]  stage_mult = RHS_MULT_RST;
  longint      level_lo = longint'(POS_LIM);
  longint      level_hi = longint'(NEG_LIM);

  function automatic longint stage_term(logic signed [31:0] div);
    longint          dv;
    longint unsigned dmag;
    longint unsigned pmag;
    longint          prod;
    dv = div;
    dmag = (dv < 0) ? -dv : dv;
    pmag = longint'({32'd0, dt_q16}) * dmag;
    prod = (dv < 0) ? -longint'(pmag) : longint'(pmag);
    return longint'(stage_mult) * (prod >>> FRAC_W);
  endfunction

  function automatic bounds_t predict_bounds(point_t p);
    bounds_t         r;
    longint          divisor;
    longint          mass;
    longint          ratio;
    longint          lo;
    longint          hi;
    longint unsigned q;
    logic            neg;
    r = '{default: '0};
    mass = p.mass;
    divisor = longint'(p.thick) - stage_term(p.div);
    if (divisor == 0) begin
      r.fault = 1'b1;
      ratio = (mass > 0) ? longint'(POS_LIM) : (mass < 0) ? longint'(NEG_LIM) : 0;
    end else begin
      q = ((mass < 0) ? -mass : mass) << FRAC_W;
      q = q / ((divisor < 0) ? -divisor : divisor);
      neg = (mass < 0) != (divisor < 0);
      if (neg) begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          r.fault = 1'b1;
        end
        ratio = -longint'(q);
      end else begin
        if (q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
          r.fault = 1'b1;
        end
        ratio = longint'(q);
      end
    end
    if (ratio < level_lo) level_lo = ratio;
    if (ratio > level_hi) level_hi = ratio;
    r.ratio = ratio[31:0];
    if (p.last_pt) begin
      lo = level_lo;
      hi = level_hi;
      if (stage_mult == MULT_MERGE) begin
        if (longint'(p.pmin) < lo) lo = p.pmin;
        if (longint'(p.pmax) > hi) hi = p.pmax;
      end
      if (lo < 0) lo = 0;
      r.lmin = lo[30:0];
      r.lmax = hi[31:0];
      r.done = 1'b1;
      level_lo = longint'(POS_LIM);
      level_hi = longint'(NEG_LIM);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_bounds.push_back(predict_bounds(pending_points.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_thickness <= pending_points[0].thick;
          in_divergence <= pending_points[0].div;
          in_tracer_mass <= pending_points[0].mass;
          in_prior_min <= pending_points[0].pmin;
          in_prior_max <= pending_points[0].pmax;
          in_last_in_level <= pending_points[0].last_pt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    bounds_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_bounds.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ratio=%h", $time, out_ratio);
        end else begin
          e = expected_bounds.pop_front();
          if (e.done) levels_seen++;
          if (e.fault) faults_seen++;
          if (out_ratio !== e.ratio) begin
            errors++;
            $display("%0t: ratio expected %h actual %h", $time, e.ratio, out_ratio);
          end
          if (out_level_min !== e.lmin) begin
            errors++;
            $display("%0t: level_min expected %h actual %h", $time, e.lmin, out_level_min);
          end
          if (out_level_max !== e.lmax) begin
            errors++;
            $display("%0t: level_max expected %h actual %h", $time, e.lmax, out_level_max);
          end
          if (out_level_done !== e.done) begin
            errors++;
            $display("%0t: level_done expected %b actual %b", $time, e.done, out_level_done);
          end
          if (out_divide_fault !== e.fault) begin
            errors++;
            $display("%0t: divide_fault expected %b actual %b", $time, e.fault,
                     out_divide_fault);
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 6000) begin
      $display("tb_tracer_ratio_level_bounds: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TIME_STEP) dt_q16 = val;
    else if (idx == REG_RHS_MULT) stage_mult = val[1:0];
  endtask

  task automatic drain();
    wait (pending_points.size() == 0 && expected_bounds.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  task automatic add_point(logic [31:0] th, logic [31:0] dv, logic [31:0] ms,
                           logic [31:0] pn, logic [31:0] px, logic lst);
    point_t p;
    p.thick = th;
    p.div = dv;
    p.mass = ms;
    p.pmin = pn;
    p.pmax = px;
    p.last_pt = lst;
    pending_points.push_back(p);
  endtask

  initial begin
    logic [31:0] dt_set[8];
    logic [1:0]  mult_set[8];
    point_t      p;
    int          len;
    dt_set = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h1, $urandom, 32'hFFFF_FFFF,
               $urandom, 32'h0000_8000};
    mult_set = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd1, 2'd0, 2'd2};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    add_point(0, 0, 0, 0, 0, 0);
    add_point(0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    add_point(0, 32'h8000_0000, 32'h8000_0000, 0, 0, 1);
    add_point(1, 0, 32'h7FFF_FFFF, 0, 0, 0);
    add_point(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0, 0);
    add_point(1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
    add_point(32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    add_point(32'h8000_0000, 0, 32'h8000_0000, 0, 0, 0);
    add_point(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0, 1);
    add_point(32'h0001_0000, 0, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    add_point(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 0, 0, 1);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase
      write_reg(REG_TIME_STEP, dt_set[ph]);
      write_reg(REG_RHS_MULT, mult_set[ph]);
      for (int n = 0; n < 230; ) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          p.div = pick_value();
          p.mass = pick_value();
          p.pmin = pick_value();
          p.pmax = pick_value();
          p.thick = pick_value();
          if ($urandom_range(9) == 0) p.thick = 32'(stage_term(p.div));
          p.last_pt = (k == len - 1) ? 1'b1 : ($urandom_range(19) == 0);
          pending_points.push_back(p);
        end
        n += len;
        wait (pending_points.size() < 8);
      end
      drain();
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;

    $display("Checked %0d points, %0d closed levels, %0d divide faults,", results_seen,
             levels_seen, faults_seen);
    $display("over eight time step and multiplier settings and four idling patterns.");
    if (errors == 0) begin
      $display("tb_tracer_ratio_level_bounds: clean");
    end else begin
      $display("tb_tracer_ratio_level_bounds: errors");
    end
    $finish;
  end

endmodule
